/* sv/rlbs_pkg.sv */
// Shared types and constants for the route lookup binary search unit.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package rlbs_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 65536;
  localparam int unsigned IDX_W           = 16;
  localparam int unsigned LEN_W           = 17;
  localparam int unsigned ADDR_W          = 32;
  localparam int unsigned PORT_W          = 8;
  localparam int unsigned CMD_Q_DEPTH     = 2;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  // Input beat, fields in interface order (first member is MSB).
  typedef struct packed {
    logic              mode;
    logic [IDX_W-1:0]  entry_index;
    logic [ADDR_W-1:0] entry_prefix;
    logic [ADDR_W-1:0] entry_mask;
    logic [ADDR_W-1:0] entry_next_hop;
    logic [PORT_W-1:0] entry_port;
    logic [ADDR_W-1:0] dest_addr;
  } req_t;

  // Result beat.
  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  match_index;
    logic [ADDR_W-1:0] hop_addr;
    logic [PORT_W-1:0] out_port;
  } res_t;

  // Classified command; key is the prefix for a write, the destination for a lookup.
  typedef struct packed {
    op_e               op;
    logic [IDX_W-1:0]  index;
    logic [ADDR_W-1:0] key;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] hop_addr;
    logic [PORT_W-1:0] port;
  } cmd_t;

  // One route table entry.
  typedef struct packed {
    logic [ADDR_W-1:0] prefix;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] hop_addr;
    logic [PORT_W-1:0] port;
  } entry_t;

endpackage

`default_nettype wire

/* sv/rlbs_front.sv */
// Front end: accepts input beats, classifies them into commands and
// queues them for the back end. Depends on rlbs_pkg.
`default_nettype none

module rlbs_front #(
  parameter int unsigned TABLE_DEPTH = rlbs_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  output logic               full_o,
  input  wire rlbs_pkg::req_t req_i,
  output logic               cmd_valid_o,
  output rlbs_pkg::cmd_t     cmd_o,
  input  wire logic          cmd_pop_i
);

  localparam int unsigned QPW = (rlbs_pkg::CMD_Q_DEPTH > 1) ? $clog2(rlbs_pkg::CMD_Q_DEPTH) : 1;
  localparam int unsigned QCW = $clog2(rlbs_pkg::CMD_Q_DEPTH + 1);

  rlbs_pkg::cmd_t cmd_q [rlbs_pkg::CMD_Q_DEPTH];
  logic [QPW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0] count_q, count_d;

  rlbs_pkg::cmd_t cmd_new;
  logic           accept;
  logic           drop;
  logic           enq;

  // Classify: out-of-range writes are dropped here.
  always_comb begin
    cmd_new.index    = req_i.entry_index;
    cmd_new.mask     = req_i.entry_mask;
    cmd_new.hop_addr = req_i.entry_next_hop;
    cmd_new.port     = req_i.entry_port;
    drop             = 1'b0;
    if (req_i.mode == rlbs_pkg::MODE_LOOKUP) begin
      cmd_new.op  = rlbs_pkg::OP_LOOKUP;
      cmd_new.key = req_i.dest_addr;
    end else begin
      cmd_new.op  = rlbs_pkg::OP_WRITE;
      cmd_new.key = req_i.entry_prefix;
      drop = ({1'b0, req_i.entry_index} >= rlbs_pkg::LEN_W'(TABLE_DEPTH));
    end
  end

  assign full_o      = (count_q == QCW'(rlbs_pkg::CMD_Q_DEPTH));
  assign accept      = push_i && !full_o;
  assign enq         = accept && !drop;
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = cmd_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (enq) begin
      wr_ptr_d = (wr_ptr_q == QPW'(rlbs_pkg::CMD_Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (cmd_pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPW'(rlbs_pkg::CMD_Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (enq && !cmd_pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!enq && cmd_pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      cmd_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

`default_nettype wire

/* sv/rlbs_back.sv */
// Back end: route table memory, binary search sequencer and result register.
// Depends on rlbs_pkg.
`default_nettype none

module rlbs_back #(
  parameter int unsigned TABLE_DEPTH = rlbs_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [rlbs_pkg::LEN_W-1:0] table_length_i,
  input  wire logic                       cmd_valid_i,
  input  wire rlbs_pkg::cmd_t             cmd_i,
  output logic                            cmd_pop_o,
  input  wire logic                       res_pop_i,
  output logic                            res_valid_o,
  output rlbs_pkg::res_t                  res_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned LW = AW + 1;
  localparam int unsigned SW = AW + 2;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_DONE   = 3'b100
  } state_e;

  rlbs_pkg::entry_t table_mem [TABLE_DEPTH];
  rlbs_pkg::entry_t rdata_q;

  state_e state_q, state_d;
  logic   res_valid_q, res_valid_d;

  logic [LW-1:0]               lo_q, end_q;
  logic [AW-1:0]               mid_q;
  logic [rlbs_pkg::ADDR_W-1:0] key_q;
  logic                        hit_q;
  logic [AW-1:0]               best_idx_q;
  logic [rlbs_pkg::ADDR_W-1:0] best_nh_q;
  logic [rlbs_pkg::PORT_W-1:0] best_port_q;
  rlbs_pkg::res_t              res_q;

  logic [rlbs_pkg::LEN_W-1:0]  len_clamp;
  logic [LW-1:0]               len;
  logic [rlbs_pkg::ADDR_W-1:0] masked;
  logic                        eq;
  logic                        go_right;
  logic [LW-1:0]               lo_n, end_n;
  logic [LW-1:0]               probe_lo, probe_end;
  logic [SW-1:0]               mid_sum;
  logic [AW-1:0]               rd_addr;
  logic                        more;
  logic                        start;
  logic                        mem_we;
  logic                        rd_en;
  logic                        res_load;

  // Clamp the configured length to the table depth.
  assign len_clamp = (table_length_i > rlbs_pkg::LEN_W'(TABLE_DEPTH))
                   ? rlbs_pkg::LEN_W'(TABLE_DEPTH) : table_length_i;
  assign len = len_clamp[LW-1:0];

  // Probe compare on the registered read data.
  assign masked   = key_q & rdata_q.mask;
  assign eq       = (rdata_q.prefix == masked);
  assign go_right = eq || (rdata_q.prefix < masked);
  assign lo_n     = go_right ? ({1'b0, mid_q} + 1'b1) : lo_q;
  assign end_n    = go_right ? end_q : {1'b0, mid_q};

  // Next probe: [lo, end) half-open range, mid = (lo + end - 1) / 2.
  assign probe_lo  = (state_q == ST_IDLE) ? '0  : lo_n;
  assign probe_end = (state_q == ST_IDLE) ? len : end_n;
  assign mid_sum   = SW'(probe_lo) + SW'(probe_end) - SW'(1);
  assign rd_addr   = mid_sum[AW:1];
  assign more      = (probe_lo < probe_end);

  assign res_load    = (state_q == ST_DONE) && (!res_valid_q || res_pop_i);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    state_d     = state_q;
    cmd_pop_o   = 1'b0;
    start       = 1'b0;
    mem_we      = 1'b0;
    rd_en       = 1'b0;
    res_valid_d = res_valid_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.op == rlbs_pkg::OP_LOOKUP) begin
            start = 1'b1;
            if (more) begin
              rd_en   = 1'b1;
              state_d = ST_SEARCH;
            end else begin
              state_d = ST_DONE;
            end
          end else begin
            mem_we = 1'b1;
          end
        end
      end
      ST_SEARCH: begin
        if (more) begin
          rd_en = 1'b1;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (res_load) begin
      res_valid_d = 1'b1;
    end else if (res_pop_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_mem[cmd_i.index[AW-1:0]] <= '{prefix:   cmd_i.key,
                                          mask:     cmd_i.mask,
                                          hop_addr: cmd_i.hop_addr,
                                          port:     cmd_i.port};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= table_mem[rd_addr];
    end
  end

  // Search datapath.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      mid_q <= rd_addr;
    end
    if (start) begin
      key_q       <= cmd_i.key;
      lo_q        <= '0;
      end_q       <= len;
      hit_q       <= 1'b0;
      best_idx_q  <= '0;
      best_nh_q   <= '0;
      best_port_q <= '0;
    end else if (state_q == ST_SEARCH) begin
      lo_q  <= lo_n;
      end_q <= end_n;
      if (eq) begin
        hit_q       <= 1'b1;
        best_idx_q  <= mid_q;
        best_nh_q   <= rdata_q.hop_addr;
        best_port_q <= rdata_q.port;
      end
    end
    if (res_load) begin
      res_q.found       <= hit_q;
      res_q.match_index <= rlbs_pkg::IDX_W'(best_idx_q);
      res_q.hop_addr    <= best_nh_q;
      res_q.out_port    <= best_port_q;
    end
  end

endmodule

`default_nettype wire

/* sv/route_lookup_binary_search_unit.sv */
// Top level of the route lookup binary search unit: config register,
// front end and back end. Depends on rlbs_pkg, rlbs_front, rlbs_back.
//
// Usage:
//   Input channel (push/full): a beat with mode 0 writes one route entry
//   at entry_index; mode 1 looks up dest_addr. Writes at an index not
//   below TABLE_DEPTH are dropped. Writes produce no result beat.
//   Result channel (empty/pop): one beat per lookup, in order. found is 0
//   with all other fields 0 when no probed entry matched.
//   Config: cfg_we_i writes table_length (clamped to TABLE_DEPTH); write it
//   only while no lookup is in flight.
// Sequencing:
//   A beat passes through the two-entry command queue. A write is then
//   done by the back end in its idle state. A lookup over n entries has a
//   start step, up to floor(log2 n)+1 probes (one table memory read each),
//   and a done step that loads the result. Commands run one at a time.
// Reset: table_length clears to 0, both queues empty; table contents are
//   undefined until written.
// Stall: a result waits in the output register while pop is low; a
//   finished lookup then holds the back end until the register frees up,
//   so no command is taken meanwhile and full rises once the queue fills.
`default_nettype none

module route_lookup_binary_search_unit #(
  parameter int unsigned TABLE_DEPTH = rlbs_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // input beats
  input  wire logic                       push,
  output logic                            full,
  input  wire rlbs_pkg::req_t             req_i,
  // result beats
  output logic                            empty,
  input  wire logic                       pop,
  output rlbs_pkg::res_t                  res_o,
  // table_length register
  input  wire logic                       cfg_we_i,
  input  wire logic [rlbs_pkg::LEN_W-1:0] cfg_wdata_i
);

  logic [rlbs_pkg::LEN_W-1:0] table_length_q;
  logic                       cmd_valid;
  logic                       cmd_pop;
  rlbs_pkg::cmd_t             cmd;
  logic                       res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_length_q <= '0;
    end else if (cfg_we_i) begin
      table_length_q <= cfg_wdata_i;
    end
  end

  rlbs_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  rlbs_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .table_length_i (table_length_q),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .cmd_pop_o      (cmd_pop),
    .res_pop_i      (pop && res_valid),
    .res_valid_o    (res_valid),
    .res_o          (res_o)
  );

  assign empty = !res_valid;

endmodule

`default_nettype wire

/* sv/rlbs_checker.sv */
// Port-level checks for the route lookup binary search unit, bound to
// the top level. Depends on rlbs_pkg and route_lookup_binary_search_unit.
`default_nettype none

module rlbs_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           push,
  input wire logic           full,
  input wire logic           empty,
  input wire logic           pop,
  input wire rlbs_pkg::res_t res_o
);

  // Held in reset: both sides show idle.
  a_reset_idle: assert property (@(posedge clk_i)
    (!rst_ni && $past(!rst_ni)) |-> (empty && !full))
    else $error("not idle during reset");

  // A miss carries all-zero fields.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !res_o.found) |->
      (res_o.match_index == '0 && res_o.hop_addr == '0 && res_o.out_port == '0))
    else $error("miss beat with nonzero fields");

  // full only rises after an accepted beat.
  a_full_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push && !full))
    else $error("full rose without an accepted beat");

  // A waiting result holds until popped.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(res_o)))
    else $error("result changed while stalled");

endmodule

bind route_lookup_binary_search_unit rlbs_checker u_rlbs_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .push   (push),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .res_o  (res_o)
);

`default_nettype wire

/* dv/tb_top.sv */
// Testbench for route_lookup_binary_search_unit: random route tables and lookups
// checked against a scoreboard that mirrors the table and searches it itself.
// Depends on rlbs_pkg and the RTL of the unit; needs nothing else.

module tb_top;

  localparam int unsigned DEPTH       = rlbs_pkg::TABLE_DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;
  // a lookup holds the back end until its result is loaded
  localparam int unsigned SETTLE      = 40;
  localparam int unsigned PHASE_BEATS = 125;

  // ------------------------------------------------------------------
  // Scoreboard: a shadow of the route table, the table_length register
  // and the queue of lookup results still owed by the unit.
  // ------------------------------------------------------------------
  class route_lookup_scoreboard;
    rlbs_pkg::entry_t route_tab [DEPTH];
    bit               written   [DEPTH];
    int unsigned      eff_len;
    rlbs_pkg::res_t   expected_results [$];
    int unsigned      mismatches;
    int unsigned      lookups;
    int unsigned      hits;
    int unsigned      writes;
    int unsigned      checked;

    function new();
      eff_len    = 0;
      mismatches = 0;
      lookups    = 0;
      hits       = 0;
      writes     = 0;
      checked    = 0;
    endfunction

    // lengths beyond the table depth search the whole table
    function void set_length(input logic [rlbs_pkg::LEN_W-1:0] value);
      eff_len = (value > DEPTH) ? DEPTH : value;
    endfunction

    // Binary search for the last matching entry. Returns the index of the
    // first unwritten entry on the probe path, or -1 when the path is clean.
    function int search_route(input logic [31:0] dest, output rlbs_pkg::res_t res);
      int          lo;
      int          hi;
      int          mid;
      logic [31:0] masked;
      res = '0;
      lo  = 0;
      hi  = int'(eff_len) - 1;
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        if (!written[mid]) return mid;
        masked = dest & route_tab[mid].mask;
        if (route_tab[mid].prefix == masked) begin
          res.found       = 1'b1;
          res.match_index = 16'(mid);
          res.hop_addr    = route_tab[mid].hop_addr;
          res.out_port    = route_tab[mid].port;
          lo = mid + 1;
        end else if (route_tab[mid].prefix < masked) begin
          lo = mid + 1;
        end else begin
          hi = mid - 1;
        end
      end
      return -1;
    endfunction

    function void note_beat(input rlbs_pkg::req_t beat);
      rlbs_pkg::res_t res;
      if (beat.mode == rlbs_pkg::MODE_WRITE) begin
        route_tab[beat.entry_index].prefix   = beat.entry_prefix;
        route_tab[beat.entry_index].mask     = beat.entry_mask;
        route_tab[beat.entry_index].hop_addr = beat.entry_next_hop;
        route_tab[beat.entry_index].port     = beat.entry_port;
        written[beat.entry_index] = 1'b1;
        writes++;
      end else begin
        void'(search_route(beat.dest_addr, res));
        expected_results.push_back(res);
        lookups++;
        if (res.found) hits++;
      end
    endfunction

    task report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(input rlbs_pkg::res_t got);
      rlbs_pkg::res_t want;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result beat %h with no lookup pending", got));
        return;
      end
      want = expected_results.pop_front();
      if (got.found !== want.found)
        report_mismatch($sformatf("result %0d found: got %b want %b",
                                  checked, got.found, want.found));
      if (got.match_index !== want.match_index)
        report_mismatch($sformatf("result %0d match_index: got %0d want %0d",
                                  checked, got.match_index, want.match_index));
      if (got.hop_addr !== want.hop_addr)
        report_mismatch($sformatf("result %0d hop_addr: got %h want %h",
                                  checked, got.hop_addr, want.hop_addr));
      if (got.out_port !== want.out_port)
        report_mismatch($sformatf("result %0d out_port: got %0d want %0d",
                                  checked, got.out_port, want.out_port));
      checked++;
    endtask
  endclass

  // ------------------------------------------------------------------
  // Clock, reset and DUT hookup. Every input has a known value at time 0.
  // ------------------------------------------------------------------
  logic                       clk_i     = 1'b0;
  logic                       rst_ni    = 1'b0;
  logic                       push      = 1'b0;
  logic                       full;
  rlbs_pkg::req_t             req       = '0;
  logic                       empty;
  logic                       pop       = 1'b0;
  rlbs_pkg::res_t             res;
  logic                       cfg_we    = 1'b0;
  logic [rlbs_pkg::LEN_W-1:0] cfg_wdata = '0;

  route_lookup_scoreboard sb = new();

  int unsigned send_idle_pct  = 17;  // sender idles this many cycles in 100
  int unsigned recv_idle_pct  = 47;  // receiver stalls this many cycles in 100
  int unsigned beats_sent     = 0;
  int unsigned settings_done  = 0;
  int unsigned cycles         = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  route_lookup_binary_search_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .req_i       (req),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, sb.expected_results.size());
      $display("route_lookup_binary_search_unit test failed");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Result side. pop is rolled fresh every cycle; a beat is taken at an
  // edge where pop was high and empty low. Values read right after the
  // edge are the ones the DUT saw at that edge.
  // ------------------------------------------------------------------
  initial begin
    @(posedge rst_ni);
    forever begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
      @(posedge clk_i);
      if (pop && !empty) sb.check_result(res);
    end
  end

  // ------------------------------------------------------------------
  // Input side.
  // ------------------------------------------------------------------

  // fields that the mode ignores still toggle, so they are all random
  function automatic rlbs_pkg::req_t random_beat();
    rlbs_pkg::req_t b;
    b.mode           = 1'($urandom);
    b.entry_index    = 16'($urandom);
    b.entry_prefix   = $urandom;
    b.entry_mask     = $urandom;
    b.entry_next_hop = $urandom;
    b.entry_port     = 8'($urandom);
    b.dest_addr      = $urandom;
    return b;
  endfunction

  // push stays high on return: the caller either sends the next beat in
  // this same step or lowers it through drain().
  task automatic send_beat(input rlbs_pkg::req_t beat);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      req  <= random_beat();
      @(posedge clk_i);
    end
    push <= 1'b1;
    req  <= beat;
    do @(posedge clk_i); while (full);
    sb.note_beat(beat);
    beats_sent++;
  endtask

  // Hold off input until every lookup answered, then let a trailing
  // write (which never answers) clear the back end.
  task automatic drain();
    push <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // only called with the DUT idle
  task automatic program_length(input logic [rlbs_pkg::LEN_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    sb.set_length(value);
    settings_done++;
  endtask

  task automatic write_entry(input int unsigned idx, input logic [31:0] prefix,
                             input logic [31:0] mask, input logic [31:0] hop,
                             input logic [7:0] port);
    rlbs_pkg::req_t beat;
    beat                = random_beat();
    beat.mode           = rlbs_pkg::MODE_WRITE;
    beat.entry_index    = 16'(idx);
    beat.entry_prefix   = prefix;
    beat.entry_mask     = mask;
    beat.entry_next_hop = hop;
    beat.entry_port     = port;
    send_beat(beat);
  endtask

  // Mostly a prefix spread evenly over the address space by index, so the
  // table comes out sorted and the search finds real matches; now and then
  // a random prefix that leaves the table unsorted.
  task automatic fill_entry(input int unsigned idx);
    logic [63:0] spread;
    logic [31:0] mask;
    int unsigned plen;
    plen = ($urandom_range(99) < 5) ? 0 : $urandom_range(32, 8);
    mask = (plen == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - plen));
    if ($urandom_range(99) < 85) begin
      spread = (64'(idx) << 32) / 64'(sb.eff_len);
      write_entry(idx, spread[31:0] & mask, mask, $urandom, 8'($urandom));
    end else begin
      write_entry(idx, $urandom & mask, mask, $urandom, 8'($urandom));
    end
  endtask

  // Load any entry the search would touch before it was ever written,
  // then issue the lookup.
  task automatic lookup(input logic [31:0] dest);
    rlbs_pkg::req_t beat;
    rlbs_pkg::res_t unused;
    int             gap;
    gap = sb.search_route(dest, unused);
    while (gap >= 0) begin
      fill_entry(gap);
      gap = sb.search_route(dest, unused);
    end
    beat           = random_beat();
    beat.mode      = rlbs_pkg::MODE_LOOKUP;
    beat.dest_addr = dest;
    send_beat(beat);
  endtask

  // Destinations: address extremes, addresses inside a stored prefix, noise.
  function automatic logic [31:0] pick_dest();
    int unsigned idx;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
    if (roll < 70 && sb.eff_len > 0) begin
      idx = $urandom_range(sb.eff_len - 1);
      if (sb.written[idx])
        return sb.route_tab[idx].prefix | ($urandom & ~sb.route_tab[idx].mask);
    end
    return $urandom;
  endfunction

  task automatic random_step();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 12) begin
      // anywhere in the table, fully random content
      write_entry($urandom_range(DEPTH - 1), $urandom, $urandom, $urandom, 8'($urandom));
    end else if (roll < 25 && sb.eff_len > 0) begin
      // rewrite inside the searched range
      fill_entry($urandom_range(sb.eff_len - 1));
    end else begin
      lookup(pick_dest());
    end
  endtask

  // ------------------------------------------------------------------
  // Stimulus.
  // ------------------------------------------------------------------
  logic [rlbs_pkg::LEN_W-1:0] phase_len [9] = '{
    17'd131071,  // long table, clamps to full depth
    17'd2,
    17'd65535,
    17'd37,
    17'd65536,
    17'd1,
    17'd1000,
    17'd0,       // empty table
    17'd0        // replaced by a random length
  };

  initial begin
    int unsigned stop_at;
    bit          paused;
    paused = 1'b0;
    phase_len[8] = 17'($urandom_range(65536, 3));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed. table_length is 0 out of reset: an empty table never hits.
    lookup($urandom);

    // small sorted table: default route, two 10/x routes, two 192.168/x
    // routes, a host route of all ones; plus the last index at all ones
    write_entry(0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 8'h00);
    write_entry(1, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_0001, 8'd1);
    write_entry(2, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_0001, 8'd2);
    write_entry(3, 32'hC0A8_0000, 32'hFFFF_0000, 32'hC0A8_0001, 8'd3);
    write_entry(4, 32'hC0A8_0100, 32'hFFFF_FF00, 32'hC0A8_0101, 8'd4);
    write_entry(5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    write_entry(DEPTH - 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    drain();
    program_length(17'd6);
    lookup(32'h0A01_0203);  // hit on the middle probe, then keeps going right
    lookup(32'hC0A8_0105);
    lookup(32'hFFFF_FFFF);  // host route at the top end
    lookup(32'h0000_0000);  // only the default route matches
    lookup(32'h0B00_0000);  // no match at all
    lookup(32'hC0A9_0000);
    // break the order: the search now follows whatever the probes say
    write_entry(2, 32'hF000_0000, 32'hF000_0000, 32'h1234_5678, 8'd22);
    lookup(32'h0A01_0203);
    lookup(32'hF123_4567);
    drain();
    program_length(17'd1);
    lookup(32'h1234_5678);

    // Random phases, one table_length each; the idle pattern changes
    // every three phases.
    for (int p = 0; p < 9; p++) begin
      if (p == 3) begin
        send_idle_pct = 47;
        recv_idle_pct = 17;
      end
      if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      drain();
      program_length(phase_len[p]);
      stop_at = beats_sent + PHASE_BEATS;
      while (beats_sent < stop_at) begin
        // once, midway through phase 4, let the unit run completely dry
        if (p == 4 && !paused && beats_sent + PHASE_BEATS / 2 >= stop_at) begin
          drain();
          paused = 1'b1;
        end
        random_step();
      end
    end

    drain();
    $display("covered %0d lookups (%0d hits) and %0d table writes",
             sb.lookups, sb.hits, sb.writes);
    $display("over %0d table_length values incl. empty, single-entry and clamped",
             settings_done);
    if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("route_lookup_binary_search_unit test passed");
    end else begin
      $display("route_lookup_binary_search_unit test failed");
    end
    $finish;
  end

endmodule
